// File: rtl/olist_pkg.sv
`default_nettype none
package olist_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 8;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W = 32;
  localparam int OUTC_W = 7;

  typedef logic [3:0]          op_t;
  typedef logic [2:0]          status_t;
  typedef logic [DATA_W-1:0]   word_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [OUTC_W-1:0]   outc_t;

  localparam op_t OP_ADD_FRONT  = 4'd0;
  localparam op_t OP_ADD_BACK   = 4'd1;
  localparam op_t OP_DEL_FRONT  = 4'd2;
  localparam op_t OP_DEL_BACK   = 4'd3;
  localparam op_t OP_INSERT_AT  = 4'd4;
  localparam op_t OP_REMOVE_AT  = 4'd5;
  localparam op_t OP_FIND       = 4'd6;
  localparam op_t OP_READ_AT    = 4'd7;
  localparam op_t OP_PEEK_FRONT = 4'd8;
  localparam op_t OP_PEEK_BACK  = 4'd9;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_BADIDX   = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  localparam cnt_t CNT_FULL = CNT_W'(DEPTH);

  // reported counts wrap to the 7-bit output field
  function automatic outc_t cnt_to_out(input cnt_t c);
    logic [CNT_W+OUTC_W-1:0] w;
    w = {{OUTC_W{1'b0}}, c};
    return w[OUTC_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/olist_if.sv
`default_nettype none
interface olist_in_if;
  logic                      valid;
  logic                      ready;
  logic [3:0]                operation;
  logic signed [31:0]        value;
  logic [7:0]                position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink (input valid, input operation, input value, input position,
                output ready);
endinterface

interface olist_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic signed [31:0]        data_out;
  logic [6:0]                found_index;
  logic [6:0]                item_count;

  modport source (output valid, output status, output data_out, output found_index,
                  output item_count, input ready);
  modport sink (input valid, input status, input data_out, input found_index,
                input item_count, output ready);
endinterface
`default_nettype wire

// File: rtl/olist_ram.sv
`default_nettype none
module olist_ram (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire olist_pkg::addr_t waddr,
  input  wire olist_pkg::word_t wdata,
  input  wire olist_pkg::addr_t raddr,
  output olist_pkg::word_t     rdata
);

  olist_pkg::word_t mem [olist_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/ordered_list_engine_top.sv
`default_nettype none
// Ordered list of up to DEPTH signed 32-bit entries, kept packed in list order in a
// single-port-read, single-port-write memory. One request is worked at a time and
// gives exactly one response. Rejected requests (full, empty, bad index, find on an
// empty list) and unknown operations go straight to the finish state, and appends
// write the new entry directly. Reads, peeks and deletes from the back read one
// entry. Deletes from the front, removes and finds walk the memory one entry per
// cycle through its one read port: from the position to the end of the list, or up
// to the first match. Inserts in front of the last entry first move each entry from
// the position on one place up, then write the new value. The response sits in an
// output register, so the request side is free again in the cycle after it is
// loaded. A stalled sink holds the finished request until the output register frees.
// No clearing pass is needed after reset.
module ordered_list_engine_top (
  input  wire logic    clk,
  input  wire logic    rst_n,
  olist_in_if.sink     in_ch,
  olist_out_if.source  out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [1:0] K_INS  = 2'd0;
  localparam logic [1:0] K_REM  = 2'd1;
  localparam logic [1:0] K_FIND = 2'd2;
  localparam logic [1:0] K_READ = 2'd3;

  logic [1:0]            state_r;
  logic [1:0]            kind_r;
  olist_pkg::cnt_t       cnt_r;
  olist_pkg::addr_t      ptr_r;
  olist_pkg::addr_t      stop_r;
  olist_pkg::addr_t      idx_r;
  olist_pkg::addr_t      q_r;
  logic                  issue_r;
  logic                  pend_r;
  olist_pkg::word_t      val_r;
  olist_pkg::status_t    res_status_r;
  olist_pkg::word_t      res_data_r;
  olist_pkg::outc_t      res_fidx_r;

  logic                  out_valid_r;
  olist_pkg::status_t    out_status_r;
  olist_pkg::word_t      out_data_r;
  olist_pkg::outc_t      out_fidx_r;
  olist_pkg::outc_t      out_count_r;

  logic                  in_fire;
  logic                  out_load;
  logic                  is_empty;
  logic                  is_full;
  logic                  pos_lt;
  logic                  append;
  logic [olist_pkg::CMP_W-1:0] pos_wide;
  olist_pkg::addr_t      pos_idx;
  olist_pkg::addr_t      last_idx;
  olist_pkg::addr_t      cnt_idx;

  logic                  ram_we;
  olist_pkg::addr_t      ram_waddr;
  olist_pkg::word_t      ram_wdata;
  olist_pkg::word_t      ram_rdata;

  olist_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_load           = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.data_out    = out_data_r;
  assign out_ch.found_index = out_fidx_r;
  assign out_ch.item_count  = out_count_r;

  always_comb begin
    is_empty = (cnt_r == '0);
    is_full  = (cnt_r == olist_pkg::CNT_FULL);
    pos_wide = olist_pkg::CMP_W'(in_ch.position);
    pos_lt   = (pos_wide < olist_pkg::CMP_W'(cnt_r));
    // only used as an address when below the count, so it fits
    pos_idx  = pos_wide[olist_pkg::ADDR_W-1:0];
    cnt_idx  = cnt_r[olist_pkg::ADDR_W-1:0];
    last_idx = cnt_idx - 1'b1;
    append   = is_empty || (in_ch.operation == olist_pkg::OP_ADD_BACK) ||
               ((in_ch.operation == olist_pkg::OP_INSERT_AT) && !pos_lt);
  end

  // memory write port: shifting during a walk, or the new value
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = val_r;
    if (state_r == S_PUT) begin
      ram_we = 1'b1;
    end else if ((state_r == S_WALK) && pend_r) begin
      case (kind_r)
        K_INS: begin
          ram_we    = 1'b1;
          ram_waddr = q_r + 1'b1;
          ram_wdata = ram_rdata;
        end
        K_REM: begin
          if (q_r != idx_r) begin
            ram_we    = 1'b1;
            ram_waddr = q_r - 1'b1;
            ram_wdata = ram_rdata;
          end
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            val_r        <= in_ch.value;
            res_data_r   <= '0;
            res_fidx_r   <= (in_ch.operation == olist_pkg::OP_FIND) ?
                            olist_pkg::cnt_to_out(cnt_r) : '0;
            issue_r      <= 1'b1;
            pend_r       <= 1'b0;
            unique case (in_ch.operation) inside
              olist_pkg::OP_ADD_FRONT, olist_pkg::OP_ADD_BACK,
              olist_pkg::OP_INSERT_AT: begin
                if (is_full) begin
                  res_status_r <= olist_pkg::ST_FULL;
                  state_r      <= S_FIN;
                end else if (append) begin
                  res_status_r <= olist_pkg::ST_OK;
                  idx_r        <= cnt_idx;
                  state_r      <= S_PUT;
                end else begin
                  res_status_r <= olist_pkg::ST_OK;
                  kind_r  <= K_INS;
                  idx_r   <= (in_ch.operation == olist_pkg::OP_ADD_FRONT) ? '0 : pos_idx;
                  stop_r  <= (in_ch.operation == olist_pkg::OP_ADD_FRONT) ? '0 : pos_idx;
                  ptr_r   <= last_idx;
                  state_r <= S_WALK;
                end
              end
              olist_pkg::OP_DEL_FRONT, olist_pkg::OP_DEL_BACK: begin
                if (is_empty) begin
                  res_status_r <= olist_pkg::ST_EMPTY;
                  state_r      <= S_FIN;
                end else begin
                  res_status_r <= olist_pkg::ST_OK;
                  kind_r  <= K_REM;
                  idx_r   <= (in_ch.operation == olist_pkg::OP_DEL_FRONT) ? '0 : last_idx;
                  ptr_r   <= (in_ch.operation == olist_pkg::OP_DEL_FRONT) ? '0 : last_idx;
                  stop_r  <= last_idx;
                  state_r <= S_WALK;
                end
              end
              olist_pkg::OP_REMOVE_AT: begin
                if (!pos_lt) begin
                  res_status_r <= olist_pkg::ST_BADIDX;
                  state_r      <= S_FIN;
                end else begin
                  res_status_r <= olist_pkg::ST_OK;
                  kind_r  <= K_REM;
                  idx_r   <= pos_idx;
                  ptr_r   <= pos_idx;
                  stop_r  <= last_idx;
                  state_r <= S_WALK;
                end
              end
              olist_pkg::OP_FIND: begin
                res_status_r <= olist_pkg::ST_NOTFOUND;
                if (!is_empty) begin
                  kind_r  <= K_FIND;
                  ptr_r   <= '0;
                  stop_r  <= last_idx;
                  state_r <= S_WALK;
                end else begin
                  state_r <= S_FIN;
                end
              end
              olist_pkg::OP_READ_AT: begin
                if (!pos_lt) begin
                  res_status_r <= olist_pkg::ST_BADIDX;
                  state_r      <= S_FIN;
                end else begin
                  res_status_r <= olist_pkg::ST_OK;
                  kind_r  <= K_READ;
                  ptr_r   <= pos_idx;
                  stop_r  <= pos_idx;
                  state_r <= S_WALK;
                end
              end
              olist_pkg::OP_PEEK_FRONT, olist_pkg::OP_PEEK_BACK: begin
                if (is_empty) begin
                  res_status_r <= olist_pkg::ST_EMPTY;
                  state_r      <= S_FIN;
                end else begin
                  res_status_r <= olist_pkg::ST_OK;
                  kind_r  <= K_READ;
                  ptr_r   <= (in_ch.operation == olist_pkg::OP_PEEK_FRONT) ? '0 : last_idx;
                  stop_r  <= (in_ch.operation == olist_pkg::OP_PEEK_FRONT) ? '0 : last_idx;
                  state_r <= S_WALK;
                end
              end
              default: begin
                res_status_r <= olist_pkg::ST_OK;
                state_r      <= S_FIN;
              end
            endcase
          end
        end

        S_WALK: begin
          // one read issued per cycle, data comes back the cycle after
          if (issue_r) begin
            pend_r <= 1'b1;
            q_r    <= ptr_r;
            if (ptr_r == stop_r) begin
              issue_r <= 1'b0;
            end else if (kind_r == K_INS) begin
              ptr_r <= ptr_r - 1'b1;
            end else begin
              ptr_r <= ptr_r + 1'b1;
            end
          end else begin
            pend_r <= 1'b0;
          end

          if (pend_r) begin
            case (kind_r)
              K_INS: begin
                if (q_r == idx_r) begin
                  state_r <= S_PUT;
                end
              end
              K_REM: begin
                if (q_r == idx_r) begin
                  res_data_r <= ram_rdata;
                end
                if (q_r == stop_r) begin
                  cnt_r   <= cnt_r - 1'b1;
                  state_r <= S_FIN;
                end
              end
              K_FIND: begin
                if (ram_rdata == val_r) begin
                  res_status_r <= olist_pkg::ST_OK;
                  res_fidx_r   <= olist_pkg::cnt_to_out(olist_pkg::CNT_W'(q_r));
                  state_r      <= S_FIN;
                end else if (q_r == stop_r) begin
                  state_r <= S_FIN;
                end
              end
              default: begin
                res_data_r <= ram_rdata;
                state_r    <= S_FIN;
              end
            endcase
          end
        end

        S_PUT: begin
          cnt_r   <= cnt_r + 1'b1;
          state_r <= S_FIN;
        end

        S_FIN: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_fidx_r   <= res_fidx_r;
      out_count_r  <= olist_pkg::cnt_to_out(cnt_r);
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_ordered_list_engine_top.sv
`default_nettype none
module tb_ordered_list_engine_top;
  import olist_pkg::*;

  localparam op_t OP_UNUSED_LO  = 4'd10;
  localparam op_t OP_UNUSED_HI  = 4'd15;
  localparam int  NUM_SEGMENTS  = 12;
  localparam int  SEG_REQS      = 77;
  localparam int  DIR_ROWS      = 25;
  localparam int  QUIET_LIMIT   = 4000;
  localparam int  DRAIN_CYCLES  = 100;

  typedef enum int {SEG_GROW, SEG_SHRINK, SEG_MIXED} seg_kind_e;
  typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_e;

  typedef struct packed {
    status_t status;
    word_t   data;
    outc_t   fidx;
    outc_t   cnt;
  } resp_t;

  typedef struct packed {
    op_t        op;
    word_t      val;
    logic [7:0] pos;
    logic       typed;
    resp_t      want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  olist_in_if  in_ch ();
  olist_out_if out_ch ();

  ordered_list_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the list, entries packed in list order
  word_t list_mem [DEPTH];
  int    list_len;

  resp_t pending_resp [$];

  int idle_pct;
  int stall_pct;
  int mismatches;
  int resp_checked;
  int req_sent;
  int peak_len;
  int full_rejects;
  int empty_hits;
  int miss_finds;
  int quiet_cycles;

  // empty list first, then a short list walked through every operation
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_PEEK_FRONT, 32'h0,         8'd0,   1'b1, '{ST_EMPTY,    32'h0,         7'd0, 7'd0}},
    '{OP_PEEK_BACK,  32'h0,         8'd0,   1'b1, '{ST_EMPTY,    32'h0,         7'd0, 7'd0}},
    '{OP_DEL_FRONT,  32'h0,         8'd0,   1'b1, '{ST_EMPTY,    32'h0,         7'd0, 7'd0}},
    '{OP_DEL_BACK,   32'h0,         8'd0,   1'b1, '{ST_EMPTY,    32'h0,         7'd0, 7'd0}},
    '{OP_REMOVE_AT,  32'h0,         8'd0,   1'b1, '{ST_BADIDX,   32'h0,         7'd0, 7'd0}},
    '{OP_READ_AT,    32'h0,         8'd0,   1'b1, '{ST_BADIDX,   32'h0,         7'd0, 7'd0}},
    '{OP_FIND,       32'h5,         8'd0,   1'b1, '{ST_NOTFOUND, 32'h0,         7'd0, 7'd0}},
    '{OP_UNUSED_HI,  32'hFFFF_FFFF, 8'hFF,  1'b1, '{ST_OK,       32'h0,         7'd0, 7'd0}},
    '{OP_ADD_BACK,   32'h7FFF_FFFF, 8'd0,   1'b1, '{ST_OK,       32'h0,         7'd0, 7'd1}},
    '{OP_ADD_FRONT,  32'h8000_0000, 8'd0,   1'b1, '{ST_OK,       32'h0,         7'd0, 7'd2}},
    '{OP_INSERT_AT,  32'hFFFF_FFFF, 8'd255, 1'b1, '{ST_OK,       32'h0,         7'd0, 7'd3}},
    '{OP_INSERT_AT,  32'h0,         8'd0,   1'b1, '{ST_OK,       32'h0,         7'd0, 7'd4}},
    '{OP_INSERT_AT,  32'h5555_5555, 8'd2,   1'b0, '0},
    '{OP_FIND,       32'h7FFF_FFFF, 8'd0,   1'b0, '0},
    '{OP_FIND,       32'd12345,     8'd0,   1'b1, '{ST_NOTFOUND, 32'h0,         7'd5, 7'd5}},
    '{OP_READ_AT,    32'h0,         8'd4,   1'b0, '0},
    '{OP_READ_AT,    32'h0,         8'd5,   1'b1, '{ST_BADIDX,   32'h0,         7'd0, 7'd5}},
    '{OP_PEEK_FRONT, 32'h0,         8'd0,   1'b0, '0},
    '{OP_PEEK_BACK,  32'h0,         8'd0,   1'b1, '{ST_OK,       32'hFFFF_FFFF, 7'd0, 7'd5}},
    '{OP_REMOVE_AT,  32'h0,         8'd0,   1'b0, '0},
    '{OP_REMOVE_AT,  32'h0,         8'd2,   1'b0, '0},
    '{OP_REMOVE_AT,  32'h0,         8'd200, 1'b1, '{ST_BADIDX,   32'h0,         7'd0, 7'd3}},
    '{OP_DEL_FRONT,  32'h0,         8'd0,   1'b1, '{ST_OK,       32'h8000_0000, 7'd0, 7'd2}},
    '{OP_DEL_BACK,   32'h0,         8'd0,   1'b0, '0},
    '{OP_UNUSED_LO,  32'h0,         8'd0,   1'b1, '{ST_OK,       32'h0,         7'd0, 7'd1}}
  };

  function automatic void list_put(input int idx, input word_t v);
    for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
    list_mem[idx] = v;
    list_len++;
  endfunction

  function automatic word_t list_take(input int idx);
    word_t v;
    v = list_mem[idx];
    for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
    return v;
  endfunction

  function automatic resp_t list_apply(input op_t op, input word_t val, input logic [7:0] pos);
    resp_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ADD_FRONT, OP_ADD_BACK, OP_INSERT_AT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_ADD_FRONT) begin
          list_put(0, val);
        end else if (op == OP_ADD_BACK || int'(pos) >= list_len) begin
          list_put(list_len, val);
        end else begin
          list_put(int'(pos), val);
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.data = list_take(op == OP_DEL_FRONT ? 0 : list_len - 1);
      end
      OP_REMOVE_AT: begin
        if (int'(pos) >= list_len) r.status = ST_BADIDX;
        else r.data = list_take(int'(pos));
      end
      OP_FIND: begin
        r.fidx   = outc_t'(list_len);
        r.status = ST_NOTFOUND;
        for (int i = 0; i < list_len; i++) begin
          if (r.status == ST_NOTFOUND && list_mem[i] == val) begin
            r.fidx   = outc_t'(i);
            r.status = ST_OK;
          end
        end
      end
      OP_READ_AT: begin
        if (int'(pos) >= list_len) r.status = ST_BADIDX;
        else r.data = list_mem[pos];
      end
      OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.data = list_mem[op == OP_PEEK_FRONT ? 0 : list_len - 1];
      end
      default: ;
    endcase
    r.cnt = outc_t'(list_len);
    return r;
  endfunction

  function automatic op_t pick_op(input seg_kind_e kind);
    int roll;
    int add_w;
    int del_w;
    roll = $urandom_range(0, 99);
    add_w = (kind == SEG_GROW) ? 60 : (kind == SEG_SHRINK) ? 15 : 38;
    del_w = (kind == SEG_GROW) ? 15 : (kind == SEG_SHRINK) ? 60 : 37;
    if (roll < 3) begin
      return op_t'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end else if (roll < 3 + add_w) begin
      case ($urandom_range(0, 2))
        0:       return OP_ADD_FRONT;
        1:       return OP_ADD_BACK;
        default: return OP_INSERT_AT;
      endcase
    end else if (roll < 3 + add_w + del_w) begin
      case ($urandom_range(0, 2))
        0:       return OP_DEL_FRONT;
        1:       return OP_DEL_BACK;
        default: return OP_REMOVE_AT;
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return OP_FIND;
      1:       return OP_READ_AT;
      2:       return OP_PEEK_FRONT;
      default: return OP_PEEK_BACK;
    endcase
  endfunction

  // small values repeat often so finds hit and duplicates build up
  function automatic word_t pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return word_t'($signed($urandom_range(0, 15)) - 8);
    if (roll < 55 && list_len > 0) return list_mem[$urandom_range(0, list_len - 1)];
    if (roll < 62) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return word_t'($urandom);
  endfunction

  function automatic logic [7:0] pick_pos();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 8'($urandom_range(0, list_len));
    if (roll < 75) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic issue_req(input op_t op, input word_t val, input logic [7:0] pos,
                           input logic typed, input resp_t want);
    resp_t pred;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= val;
    in_ch.position  <= pos;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pred = list_apply(op, val, pos);
    pending_resp.push_back(typed ? want : pred);
    req_sent++;
    if (list_len > peak_len) peak_len = list_len;
    if (pred.status == ST_FULL) full_rejects++;
    if (pred.status == ST_EMPTY) empty_hits++;
    if (pred.status == ST_NOTFOUND && op == OP_FIND) miss_finds++;
  endtask

  task automatic set_pace(input pace_e pace);
    idle_pct  = (pace == PACE_SRC_IDLE) ? 48 : (pace == PACE_BOTH) ? 29 : 0;
    stall_pct = (pace == PACE_SNK_STALL) ? 48 : (pace == PACE_BOTH) ? 29 : 0;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    resp_t got;
    resp_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.status, out_ch.data_out, out_ch.found_index, out_ch.item_count};
      if (pending_resp.size() == 0) begin
        mismatches++;
        $display("%0t: response with no request pending: st=%0d data=%h idx=%0d cnt=%0d",
                 $time, got.status, got.data, got.fidx, got.cnt);
      end else begin
        want = pending_resp.pop_front();
        resp_checked++;
        if (got !== want) begin
          mismatches++;
          $display("%0t: mismatch expected st=%0d data=%h idx=%0d cnt=%0d", $time,
                   want.status, want.data, want.fidx, want.cnt);
          $display("%0t:          actual   st=%0d data=%h idx=%0d cnt=%0d", $time,
                   got.status, got.data, got.fidx, got.cnt);
        end
      end
    end
  end

  // stall watchdog: nothing moving on either channel for too long
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    seg_kind_e plan [NUM_SEGMENTS];
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_ADD_FRONT;
    in_ch.value     = '0;
    in_ch.position  = '0;
    out_ch.ready    = 1'b0;
    list_len        = 0;
    mismatches      = 0;
    resp_checked    = 0;
    req_sent        = 0;
    peak_len        = 0;
    full_rejects    = 0;
    empty_hits      = 0;
    miss_finds      = 0;
    quiet_cycles    = 0;
    set_pace(PACE_FULL);
    // two grow phases in a row reach a full list, two shrink phases drain it
    plan = '{SEG_GROW, SEG_GROW, SEG_MIXED, SEG_SHRINK, SEG_SHRINK, SEG_MIXED,
             SEG_GROW, SEG_GROW, SEG_GROW, SEG_SHRINK, SEG_SHRINK, SEG_MIXED};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      issue_req(dir_rows[r].op, dir_rows[r].val, dir_rows[r].pos,
                dir_rows[r].typed, dir_rows[r].want);
    end

    for (int s = 0; s < NUM_SEGMENTS; s++) begin
      op_t        op;
      word_t      val;
      logic [7:0] pos;
      set_pace(pace_e'(s % 4));
      for (int k = 0; k < SEG_REQS; k++) begin
        op  = pick_op(plan[s]);
        val = pick_value();
        pos = pick_pos();
        issue_req(op, val, pos, 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_resp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests and %0d checked responses, list peaked at %0d entries",
             req_sent, resp_checked, peak_len);
    $display("full rejections %0d, empty-list responses %0d, failed finds %0d",
             full_rejects, empty_hits, miss_finds);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
rtl/olist_pkg.sv
rtl/olist_if.sv
rtl/olist_ram.sv
rtl/ordered_list_engine_top.sv
tb/sv/tb_ordered_list_engine_top.sv
